>>> design/modbus_rtu_request_framer_assert.svh
// assertion macros for the modbus rtu request framer
// used by the top level only, expects clk_i and rst_ni in scope
`ifndef MODBUS_RTU_REQUEST_FRAMER_ASSERT_SVH
`define MODBUS_RTU_REQUEST_FRAMER_ASSERT_SVH

// same-cycle implication
`define MRF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("framer assertion failed");

// next-cycle implication
`define MRF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("framer assertion failed");

`endif

>>> design/mrf_pkg.sv
// shared types, constants and functions of the modbus rtu request framer
// no dependencies
package mrf_pkg;

  localparam logic [7:0]  FC_LOW_FIRST  = 8'd1;
  localparam logic [7:0]  FC_LOW_LAST   = 8'd6;
  localparam logic [7:0]  FC_COILS      = 8'd15;
  localparam logic [7:0]  FC_REGS       = 8'd16;
  localparam logic [7:0]  FC_READ_WRITE = 8'd23;
  localparam logic [7:0]  SLAVE_RESET   = 8'd1;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_ACCEPTED = 2'd1,
    KIND_NONSENSE = 2'd2
  } kind_e;

  typedef enum logic [13:0] {
    PH_HUNT  = 14'b00000000000001,
    PH_FUNC  = 14'b00000000000010,
    PH_W1H   = 14'b00000000000100,
    PH_W1L   = 14'b00000000001000,
    PH_W2H   = 14'b00000000010000,
    PH_W2L   = 14'b00000000100000,
    PH_W3H   = 14'b00000001000000,
    PH_W3L   = 14'b00000010000000,
    PH_W4H   = 14'b00000100000000,
    PH_W4L   = 14'b00001000000000,
    PH_COUNT = 14'b00010000000000,
    PH_DATA  = 14'b00100000000000,
    PH_CRC1  = 14'b01000000000000,
    PH_CRC2  = 14'b10000000000000
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [7:0]  function_code;
    logic [15:0] word_one;
    logic [15:0] word_two;
    logic [15:0] word_three;
    logic [15:0] word_four;
    logic [7:0]  byte_count;
  } result_t;

  // one byte through the reflected crc-16, bit by bit
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic code_ok(input logic [7:0] fc);
    return ((fc >= FC_LOW_FIRST) && (fc <= FC_LOW_LAST)) || (fc == FC_COILS) ||
           (fc == FC_REGS) || (fc == FC_READ_WRITE);
  endfunction

endpackage

>>> design/mrf_in_reg.sv
// input register for received bytes
// depends on nothing but the clock and reset
module mrf_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_byte_i,
  output logic       in_ready_o,
  input  logic       take_i,
  output logic       held_valid_o,
  output logic [7:0] held_byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign in_ready_o   = !valid_q || take_i;
  assign held_valid_o = valid_q;
  assign held_byte_o  = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

endmodule

>>> design/mrf_parser.sv
// frame parser: phase state, held frame fields and running crc-16
// depends on mrf_pkg
module mrf_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [7:0]      byte_i,
  input  logic [7:0]      slave_addr_i,
  output logic            emit_o,
  output mrf_pkg::result_t res_o
);
  import mrf_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  func_q, func_d;
  logic [7:0]  high_q, high_d;
  logic [15:0] w1_q, w1_d, w2_q, w2_d, w3_q, w3_d, w4_q, w4_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  left_q, left_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [15:0] crc_fed;
  logic [15:0] rx_word;
  logic [7:0]  left_dec;
  result_t     framed;
  result_t     nonsense;

  assign crc_fed  = crc_feed(crc_q, byte_i);
  assign rx_word  = {high_q, byte_i};
  assign left_dec = left_q - 8'd1;

  always_comb begin
    framed.kind          = KIND_PAYLOAD;
    framed.payload_byte  = 8'd0;
    framed.function_code = func_q;
    framed.word_one      = w1_q;
    framed.word_two      = w2_q;
    framed.word_three    = w3_q;
    framed.word_four     = w4_q;
    framed.byte_count    = count_q;
    nonsense             = '0;
    nonsense.kind        = KIND_NONSENSE;
  end

  always_comb begin
    phase_d  = phase_q;
    func_d   = func_q;
    high_d   = high_q;
    w1_d     = w1_q;
    w2_d     = w2_q;
    w3_d     = w3_q;
    w4_d     = w4_q;
    count_d  = count_q;
    left_d   = left_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    emit_o   = 1'b0;
    res_o    = nonsense;
    case (phase_q)
      PH_HUNT: begin
        if (byte_i == slave_addr_i) begin
          crc_d   = crc_feed(CRC_INIT, byte_i);
          func_d  = 8'd0;
          w1_d    = 16'd0;
          w2_d    = 16'd0;
          w3_d    = 16'd0;
          w4_d    = 16'd0;
          count_d = 8'd0;
          left_d  = 8'd0;
          phase_d = PH_FUNC;
        end
      end
      PH_FUNC: begin
        if (!code_ok(byte_i)) begin
          emit_o  = 1'b1;
          phase_d = PH_HUNT;
        end else begin
          func_d  = byte_i;
          crc_d   = crc_fed;
          phase_d = PH_W1H;
        end
      end
      PH_W1H, PH_W2H, PH_W3H, PH_W4H: begin
        high_d = byte_i;
        crc_d  = crc_fed;
        case (phase_q)
          PH_W1H:  phase_d = PH_W1L;
          PH_W2H:  phase_d = PH_W2L;
          PH_W3H:  phase_d = PH_W3L;
          default: phase_d = PH_W4L;
        endcase
      end
      PH_W1L: begin
        crc_d   = crc_fed;
        w1_d    = rx_word;
        phase_d = PH_W2H;
      end
      PH_W2L: begin
        crc_d = crc_fed;
        w2_d  = rx_word;
        if (func_q == FC_READ_WRITE) begin
          phase_d = PH_W3H;
        end else if (func_q == FC_COILS || func_q == FC_REGS) begin
          phase_d = PH_COUNT;
        end else begin
          phase_d = PH_CRC1;
        end
      end
      PH_W3L: begin
        crc_d   = crc_fed;
        w3_d    = rx_word;
        phase_d = PH_W4H;
      end
      PH_W4L: begin
        crc_d   = crc_fed;
        w4_d    = rx_word;
        phase_d = PH_COUNT;
      end
      PH_COUNT: begin
        crc_d   = crc_fed;
        count_d = byte_i;
        left_d  = byte_i;
        phase_d = (byte_i == 8'd0) ? PH_CRC1 : PH_DATA;
      end
      PH_DATA: begin
        crc_d  = crc_fed;
        left_d = left_dec;
        if (left_dec == 8'd0) begin
          phase_d = PH_CRC1;
        end
        emit_o             = 1'b1;
        res_o              = framed;
        res_o.payload_byte = byte_i;
      end
      PH_CRC1: begin
        crc_lo_d = byte_i;
        phase_d  = PH_CRC2;
      end
      PH_CRC2: begin
        emit_o  = 1'b1;
        phase_d = PH_HUNT;
        // crc travels low byte first
        if ({byte_i, crc_lo_q} == crc_q) begin
          res_o      = framed;
          res_o.kind = KIND_ACCEPTED;
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      func_q   <= 8'd0;
      high_q   <= 8'd0;
      w1_q     <= 16'd0;
      w2_q     <= 16'd0;
      w3_q     <= 16'd0;
      w4_q     <= 16'd0;
      count_q  <= 8'd0;
      left_q   <= 8'd0;
      crc_q    <= CRC_INIT;
      crc_lo_q <= 8'd0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      func_q   <= func_d;
      high_q   <= high_d;
      w1_q     <= w1_d;
      w2_q     <= w2_d;
      w3_q     <= w3_d;
      w4_q     <= w4_d;
      count_q  <= count_d;
      left_q   <= left_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
    end
  end

endmodule

>>> design/mrf_out_reg.sv
// result register on the output channel
// depends on mrf_pkg
module mrf_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  mrf_pkg::result_t res_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mrf_pkg::result_t res_o
);
  import mrf_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

>>> design/modbus_rtu_request_framer.sv
// modbus rtu request framer: one byte per cycle while not stalled, results on registered outputs
// path: byte held in the input register, then its result (if any) loaded into the result register
// throughput: one byte per cycle; a byte stalls only while it yields a result and the
//   result register still holds an untaken word
// reset (rst_ni low, asynchronous): address hunt, crc all ones, slave address 1
// depends on mrf_pkg, mrf_in_reg, mrf_parser, mrf_out_reg and the assertion header
`include "modbus_rtu_request_framer_assert.svh"

module modbus_rtu_request_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  function_code_o,
  output logic [15:0] word_one_o,
  output logic [15:0] word_two_o,
  output logic [15:0] word_three_o,
  output logic [15:0] word_four_o,
  output logic [7:0]  byte_count_o
);
  import mrf_pkg::*;

  logic       [7:0] slave_addr_q;
  logic             held_valid;
  logic       [7:0] held_byte;
  logic             emit;
  logic             out_free;
  logic             advance;
  result_t          res_next;
  result_t          res_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= SLAVE_RESET;
    end else if (cfg_valid_i) begin
      slave_addr_q <= cfg_data_i;
    end
  end

  // a byte with no result never waits on the output side
  assign advance = held_valid && (out_free || !emit);

  mrf_in_reg u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_byte_i   (in_byte_i),
    .in_ready_o  (in_ready_o),
    .take_i      (advance),
    .held_valid_o(held_valid),
    .held_byte_o (held_byte)
  );

  mrf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .byte_i      (held_byte),
    .slave_addr_i(slave_addr_q),
    .emit_o      (emit),
    .res_o       (res_next)
  );

  mrf_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && emit),
    .res_i      (res_next),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res_out)
  );

  assign out_kind_o      = res_out.kind;
  assign payload_byte_o  = res_out.payload_byte;
  assign function_code_o = res_out.function_code;
  assign word_one_o      = res_out.word_one;
  assign word_two_o      = res_out.word_two;
  assign word_three_o    = res_out.word_three;
  assign word_four_o     = res_out.word_four;
  assign byte_count_o    = res_out.byte_count;

  `MRF_ASSERT_NOW(a_nonsense_clear,
    out_valid_o && (out_kind_o == KIND_NONSENSE),
    (function_code_o == 8'd0) && (byte_count_o == 8'd0) && (word_one_o == 16'd0))
  `MRF_ASSERT_NOW(a_payload_code,
    out_valid_o && (out_kind_o == KIND_PAYLOAD),
    (function_code_o == FC_COILS) || (function_code_o == FC_REGS) ||
    (function_code_o == FC_READ_WRITE))
  `MRF_ASSERT_NOW(a_stall_cause, !in_ready_o, out_valid_o && !out_ready_i)
  `MRF_ASSERT_NEXT(a_held_kept, out_valid_o && !out_ready_i, out_valid_o && $stable(out_kind_o))

endmodule

>>> verif/mrf_tb_pkg.sv
`timescale 1ns / 100ps
// frame scoreboard for the modbus rtu request framer testbench
// predicts result words from accepted bytes and checks them in order, depends on mrf_pkg
package mrf_tb_pkg;
  import mrf_pkg::*;

  class frame_scoreboard;
    logic [7:0]  slave_addr;
    phase_e      parse_phase;
    logic [7:0]  fn_code;
    logic [7:0]  hi_byte;
    logic [7:0]  cnt;
    logic [7:0]  left;
    logic [7:0]  crc_lo;
    logic [15:0] w1;
    logic [15:0] w2;
    logic [15:0] w3;
    logic [15:0] w4;
    logic [15:0] crc;
    result_t     pending_results[$];
    int          mismatches;

    function new();
      slave_addr  = SLAVE_RESET;
      parse_phase = PH_HUNT;
      fn_code     = '0;
      hi_byte     = '0;
      cnt         = '0;
      left        = '0;
      crc_lo      = '0;
      w1          = '0;
      w2          = '0;
      w3          = '0;
      w4          = '0;
      crc         = CRC_INIT;
      mismatches  = 0;
    endfunction

    // reflected crc-16, lsb first
    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
    endfunction

    static function bit is_function_code(logic [7:0] fc);
      return fc inside {[FC_LOW_FIRST:FC_LOW_LAST], FC_COILS, FC_REGS, FC_READ_WRITE};
    endfunction

    function void push_result(kind_e k, logic [7:0] data, bit with_frame);
      result_t r;
      r.kind          = k;
      r.payload_byte  = data;
      r.function_code = with_frame ? fn_code : 8'h00;
      r.word_one      = with_frame ? w1 : 16'h0000;
      r.word_two      = with_frame ? w2 : 16'h0000;
      r.word_three    = with_frame ? w3 : 16'h0000;
      r.word_four     = with_frame ? w4 : 16'h0000;
      r.byte_count    = with_frame ? cnt : 8'h00;
      pending_results = {pending_results, r};
    endfunction

    function void parse_byte(logic [7:0] b);
      case (parse_phase)
        PH_HUNT: begin
          if (b == slave_addr) begin
            crc         = crc_step(CRC_INIT, b);
            fn_code     = '0;
            w1          = '0;
            w2          = '0;
            w3          = '0;
            w4          = '0;
            cnt         = '0;
            left        = '0;
            parse_phase = PH_FUNC;
          end
        end
        PH_FUNC: begin
          if (!is_function_code(b)) begin
            // rejected code is not taken as an address
            parse_phase = PH_HUNT;
            push_result(KIND_NONSENSE, 8'h00, 1'b0);
          end else begin
            fn_code     = b;
            crc         = crc_step(crc, b);
            parse_phase = PH_W1H;
          end
        end
        PH_CRC1: begin
          crc_lo      = b;
          parse_phase = PH_CRC2;
        end
        PH_CRC2: begin
          parse_phase = PH_HUNT;
          if ({b, crc_lo} == crc) push_result(KIND_ACCEPTED, 8'h00, 1'b1);
          else push_result(KIND_NONSENSE, 8'h00, 1'b0);
        end
        default: begin
          crc = crc_step(crc, b);
          case (parse_phase)
            PH_W1H: begin
              hi_byte     = b;
              parse_phase = PH_W1L;
            end
            PH_W1L: begin
              w1          = {hi_byte, b};
              parse_phase = PH_W2H;
            end
            PH_W2H: begin
              hi_byte     = b;
              parse_phase = PH_W2L;
            end
            PH_W2L: begin
              w2 = {hi_byte, b};
              if (fn_code == FC_READ_WRITE) parse_phase = PH_W3H;
              else if (fn_code == FC_COILS || fn_code == FC_REGS) parse_phase = PH_COUNT;
              else parse_phase = PH_CRC1;
            end
            PH_W3H: begin
              hi_byte     = b;
              parse_phase = PH_W3L;
            end
            PH_W3L: begin
              w3          = {hi_byte, b};
              parse_phase = PH_W4H;
            end
            PH_W4H: begin
              hi_byte     = b;
              parse_phase = PH_W4L;
            end
            PH_W4L: begin
              w4          = {hi_byte, b};
              parse_phase = PH_COUNT;
            end
            PH_COUNT: begin
              cnt         = b;
              left        = b;
              parse_phase = (b == 8'h00) ? PH_CRC1 : PH_DATA;
            end
            PH_DATA: begin
              left = left - 8'd1;
              if (left == 8'h00) parse_phase = PH_CRC1;
              push_result(KIND_PAYLOAD, b, 1'b1);
            end
            default: parse_phase = PH_HUNT;
          endcase
        end
      endcase
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 200) $display("%0t framer check: %s", $time, what);
    endtask

    task compare(string field, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %h expected %h", field, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected word, kind %0d", got.kind));
        return;
      end
      want = pending_results.pop_front();
      compare("kind", 16'(got.kind), 16'(want.kind));
      compare("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
      compare("function_code", 16'(got.function_code), 16'(want.function_code));
      compare("word_one", got.word_one, want.word_one);
      compare("word_two", got.word_two, want.word_two);
      compare("word_three", got.word_three, want.word_three);
      compare("word_four", got.word_four, want.word_four);
      compare("byte_count", 16'(got.byte_count), 16'(want.byte_count));
    endtask

    task flag_leftovers();
      while (pending_results.size() != 0) begin
        report($sformatf("expected word never came, kind %0d", pending_results[0].kind));
        void'(pending_results.pop_front());
      end
    endtask
  endclass

endpackage

>>> verif/testbench.sv
`timescale 1ns / 100ps
// top of the modbus rtu request framer testbench: feeds directed and random byte streams
// with random idling on both sides; depends on mrf_pkg, mrf_tb_pkg and the framer rtl
module testbench;
  import mrf_pkg::*;
  import mrf_tb_pkg::*;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i  = 8'h00;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i   = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  out_kind_o;
  logic [7:0]  payload_byte_o;
  logic [7:0]  function_code_o;
  logic [15:0] word_one_o;
  logic [15:0] word_two_o;
  logic [15:0] word_three_o;
  logic [15:0] word_four_o;
  logic [7:0]  byte_count_o;

  frame_scoreboard board = new();
  int unsigned     send_gap_pct   = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     frame_bytes    = 0;
  logic [7:0]      addr_now       = SLAVE_RESET;

  modbus_rtu_request_framer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_kind_o      (out_kind_o),
    .payload_byte_o  (payload_byte_o),
    .function_code_o (function_code_o),
    .word_one_o      (word_one_o),
    .word_two_o      (word_two_o),
    .word_three_o    (word_three_o),
    .word_four_o     (word_four_o),
    .byte_count_o    (byte_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // result side: take a word when valid and ready were both high before the edge
  always @(posedge clk_i) begin
    result_t got;
    if (out_valid_o && out_ready_i) begin
      got.kind          = kind_e'(out_kind_o);
      got.payload_byte  = payload_byte_o;
      got.function_code = function_code_o;
      got.word_one      = word_one_o;
      got.word_two      = word_two_o;
      got.word_three    = word_three_o;
      got.word_four     = word_four_o;
      got.byte_count    = byte_count_o;
      board.check_result(got);
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.parse_byte(b);
  endtask

  // idle the sender until every expected word has come, then let the pipe settle
  task automatic drain_results();
    int unsigned waited = 0;
    in_valid_i <= 1'b0;
    while (board.pending_results.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_address(input logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i      <= 1'b0;
    board.slave_addr = v;
    addr_now         = v;
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(8))
      6:       return FC_COILS;
      7:       return FC_REGS;
      8:       return FC_READ_WRITE;
      default: return FC_LOW_FIRST + 8'($urandom_range(5));
    endcase
  endfunction

  // mostly short payloads, now and then a long one
  function automatic int unsigned pick_count();
    return ($urandom_range(39) == 0) ? $urandom_range(255) : $urandom_range(6);
  endfunction

  // keep of zero sends the whole frame, otherwise at most its first keep bytes
  task automatic send_frame(input logic [7:0] fc, input int unsigned cnt, input bit good,
                            input int unsigned keep);
    logic [7:0]  frame_q[$];
    logic [15:0] c;
    frame_q = {frame_q, addr_now};
    frame_q = {frame_q, fc};
    repeat ((fc == FC_READ_WRITE) ? 8 : 4) frame_q = {frame_q, 8'($urandom)};
    if (fc == FC_COILS || fc == FC_REGS || fc == FC_READ_WRITE) begin
      frame_q = {frame_q, 8'(cnt)};
      repeat (cnt) frame_q = {frame_q, 8'($urandom)};
    end
    c = CRC_INIT;
    foreach (frame_q[k]) c = frame_scoreboard::crc_step(c, frame_q[k]);
    if (!good) c ^= 16'($urandom_range(65535, 1));
    frame_q = {frame_q, c[7:0]};
    frame_q = {frame_q, c[15:8]};
    if (keep != 0 && keep < frame_q.size()) frame_q = frame_q[0:keep-1];
    foreach (frame_q[k]) send_byte(frame_q[k]);
    frame_bytes += frame_q.size();
  endtask

  task automatic send_bad_code();
    logic [7:0] b;
    do b = 8'($urandom); while (frame_scoreboard::is_function_code(b));
    send_byte(addr_now);
    send_byte(b);
    frame_bytes += 2;
  endtask

  task automatic run_segment(input int unsigned target);
    int unsigned start_bytes;
    int unsigned r;
    bit          paused = 1'b0;
    start_bytes = frame_bytes;
    while (frame_bytes - start_bytes < target) begin
      if (!paused && frame_bytes - start_bytes >= target / 2) begin
        drain_results();
        paused = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 70) send_frame(pick_code(), pick_count(), 1'b1, 0);
      else if (r < 80) send_frame(pick_code(), pick_count(), 1'b0, 0);
      else if (r < 88) send_bad_code();
      else if (r < 94) send_frame(pick_code(), pick_count(), 1'($urandom_range(1)),
                                  $urandom_range(6, 1));
      else repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_gap_pct   = 25;
    recv_stall_pct = 53;
    // foreign bytes while hunting, then bad function codes at both ends
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(addr_now);
    send_byte(8'h00);
    send_byte(addr_now);
    send_byte(8'hFF);
    // register write with empty payload, then a read with a broken crc
    send_frame(FC_REGS, 0, 1'b1, 0);
    send_frame(FC_LOW_FIRST, 0, 1'b0, 0);
    drain_results();

    write_address(8'h00);
    run_segment(230);
    drain_results();

    send_gap_pct   = 53;
    recv_stall_pct = 25;
    write_address(8'hFF);
    run_segment(230);
    drain_results();

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    write_address(8'($urandom));
    run_segment(230);
    drain_results();

    board.flag_leftovers();
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/mrf_pkg.sv
design/mrf_in_reg.sv
design/mrf_parser.sv
design/mrf_out_reg.sv
design/modbus_rtu_request_framer.sv
verif/mrf_tb_pkg.sv
verif/testbench.sv
